// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the projector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ypp_pkg.sv =====
// ----------------------------------------------------------------------------
// ypp_pkg
// Widths, types, constants and helpers of the perspective projector.
// ----------------------------------------------------------------------------
`default_nettype none

package ypp_pkg;

    localparam int SCREEN_CENTER_X = 640;
    localparam int SCREEN_CENTER_Y = 360;

    localparam int PW = 33;          // world minus camera
    localparam int RW = 36;          // after yaw rotation
    localparam int CW = 37;          // camera space coordinates
    localparam int DW = 37;          // divisor and remainder
    localparam int NW = 54;          // dividend
    localparam int QW = 44;          // quotient bits, one cell each
    localparam int HW = NW - QW;     // dividend bits preloaded into remainder

    localparam logic signed [CW-1:0] NEAR_LIMIT = CW'(655);
    localparam logic signed [39:0] OFFSCREEN = -40'sd65536000000;
    localparam logic signed [62:0] MAX40_W = 63'sd549755813887;
    localparam logic signed [62:0] MIN40_W = -63'sd549755813888;
    localparam logic signed [62:0] CENTER_X_Q = 63'(longint'(SCREEN_CENTER_X) << 16);
    localparam logic signed [62:0] CENTER_Y_Q = 63'(longint'(SCREEN_CENTER_Y) << 16);

    typedef enum logic [2:0] {
        REG_CAM_X     = 3'd0,
        REG_CAM_Y     = 3'd1,
        REG_CAM_Z     = 3'd2,
        REG_COS_YAW   = 3'd3,
        REG_SIN_YAW   = 3'd4,
        REG_COS_PITCH = 3'd5,
        REG_SIN_PITCH = 3'd6,
        REG_FOCAL     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] nq;   // dividend bits still to bring down, quotient shifts in
    } div_lane_t;

    typedef struct packed {
        logic                 behind;
        logic                 neg_x;
        logic                 neg_z;
        logic signed [CW-1:0] depth;
        logic [DW-1:0]        den;
        div_lane_t            lx;
        div_lane_t            lz;
        div_lane_t            ls;
    } div_cell_t;

    typedef struct packed {
        logic signed [39:0] screen_x;
        logic signed [39:0] screen_y;
        logic signed [39:0] depth;
        logic [31:0]        scale;
        logic               behind;
    } result_t;

    function automatic div_lane_t div_step(div_lane_t lane, logic [DW-1:0] den);
        logic [DW:0] trial;
        logic        ge;
        div_lane_t   res;
        trial = {lane.rem, lane.nq[QW-1]};
        ge = trial >= {1'b0, den};
        if (ge)
        begin
            res.rem = DW'(trial - {1'b0, den});
        end
        else
        begin
            res.rem = trial[DW-1:0];
        end
        res.nq = {lane.nq[QW-2:0], ge};
        return res;
    endfunction

    function automatic logic signed [39:0] sat40(logic signed [62:0] v);
        logic signed [39:0] r;
        if (v > MAX40_W)
        begin
            r = MAX40_W[39:0];
        end
        else if (v < MIN40_W)
        begin
            r = MIN40_W[39:0];
        end
        else
        begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ypp_rotate.sv =====
// ----------------------------------------------------------------------------
// ypp_rotate
// Translation, yaw and pitch rotation, near test and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module ypp_rotate import ypp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] world_x,
    input  wire logic signed [31:0] world_y,
    input  wire logic signed [31:0] world_z,
    input  wire logic signed [31:0] cam_x,
    input  wire logic signed [31:0] cam_y,
    input  wire logic signed [31:0] cam_z,
    input  wire logic signed [15:0] cos_yaw,
    input  wire logic signed [15:0] sin_yaw,
    input  wire logic signed [15:0] cos_pitch,
    input  wire logic signed [15:0] sin_pitch,
    input  wire logic [31:0]        focal_gain,
    output logic                    out_valid,
    output div_cell_t               out_cell
);

    logic [5:0] valid_reg;

    logic signed [PW-1:0] px_reg, py_reg, pz_reg;
    logic signed [48:0]   ma_reg, mb_reg, mc_reg, md_reg;
    logic signed [PW-1:0] pz2_reg;
    logic signed [RW-1:0] x1_reg, y1_reg;
    logic signed [PW-1:0] z1_reg;
    logic signed [51:0]   na_reg, nc_reg;
    logic signed [48:0]   nb_reg, nd_reg;
    logic signed [RW-1:0] x1b_reg;
    logic signed [CW-1:0] xc_reg, yc_reg, zc_reg;
    div_cell_t            cell_reg;

    logic [49:0]   sum_x, sum_y;
    logic [52:0]   sum_yc, sum_zc;
    logic          neg_x, neg_z;
    logic [CW-1:0] abs_x, abs_z;
    logic [NW-1:0] num_x, num_z, num_s;
    div_cell_t     cell_next;

    always_comb
    begin
        sum_x  = {ma_reg[48], ma_reg} + {mb_reg[48], mb_reg} + 50'd8192;
        sum_y  = {md_reg[48], md_reg} - {mc_reg[48], mc_reg} + 50'd8192;
        sum_yc = {na_reg[51], na_reg} + {{4{nb_reg[48]}}, nb_reg} + 53'd8192;
        sum_zc = {nc_reg[51], nc_reg} - {{4{nd_reg[48]}}, nd_reg} + 53'd8192;

        neg_x = xc_reg[CW-1];
        neg_z = zc_reg[CW-1];
        abs_x = neg_x ? CW'(-xc_reg) : xc_reg;
        abs_z = neg_z ? CW'(-zc_reg) : zc_reg;
        num_x = {1'b0, abs_x[CW-2:0], 17'd0} + {17'd0, yc_reg};
        num_z = {1'b0, abs_z[CW-2:0], 17'd0} + {17'd0, yc_reg};
        num_s = {5'd0, focal_gain, 17'd0} + {17'd0, yc_reg};

        cell_next.behind = yc_reg <= NEAR_LIMIT;
        cell_next.neg_x  = neg_x;
        cell_next.neg_z  = neg_z;
        cell_next.depth  = yc_reg;
        cell_next.den    = {yc_reg[CW-2:0], 1'b0};
        cell_next.lx.rem = {{(DW-HW){1'b0}}, num_x[NW-1:QW]};
        cell_next.lx.nq  = num_x[QW-1:0];
        cell_next.lz.rem = {{(DW-HW){1'b0}}, num_z[NW-1:QW]};
        cell_next.lz.nq  = num_z[QW-1:0];
        cell_next.ls.rem = {{(DW-HW){1'b0}}, num_s[NW-1:QW]};
        cell_next.ls.nq  = num_s[QW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= {world_x[31], world_x} - {cam_x[31], cam_x};
            py_reg   <= {world_y[31], world_y} - {cam_y[31], cam_y};
            pz_reg   <= {world_z[31], world_z} - {cam_z[31], cam_z};

            ma_reg   <= px_reg * cos_yaw;
            mb_reg   <= py_reg * sin_yaw;
            mc_reg   <= px_reg * sin_yaw;
            md_reg   <= py_reg * cos_yaw;
            pz2_reg  <= pz_reg;

            x1_reg   <= sum_x[49:14];
            y1_reg   <= sum_y[49:14];
            z1_reg   <= pz2_reg;

            na_reg   <= y1_reg * cos_pitch;
            nb_reg   <= z1_reg * sin_pitch;
            nc_reg   <= y1_reg * sin_pitch;
            nd_reg   <= z1_reg * cos_pitch;
            x1b_reg  <= x1_reg;

            yc_reg   <= sum_yc[50:14];
            zc_reg   <= sum_zc[50:14];
            xc_reg   <= {x1b_reg[RW-1], x1b_reg};

            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_cell  = cell_reg;

endmodule

`default_nettype wire

// ===== src/ypp_div_cell.sv =====
// ----------------------------------------------------------------------------
// ypp_div_cell
// One restoring division step for the x, z and scale quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module ypp_div_cell import ypp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire div_cell_t in_cell,
    output logic           out_valid,
    output div_cell_t      out_cell
);

    logic      valid_reg;
    div_cell_t cell_reg;
    div_cell_t cell_next;

    always_comb
    begin
        cell_next    = in_cell;
        cell_next.lx = div_step(in_cell.lx, in_cell.den);
        cell_next.lz = div_step(in_cell.lz, in_cell.den);
        cell_next.ls = div_step(in_cell.ls, in_cell.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

`default_nettype wire

// ===== src/ypp_finish.sv =====
// ----------------------------------------------------------------------------
// ypp_finish
// Focal scaling of the ratios, screen offset, saturation and behind forcing.
// ----------------------------------------------------------------------------
`default_nettype none

module ypp_finish import ypp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [31:0] focal_gain,
    input  wire logic        in_valid,
    input  wire div_cell_t   in_cell,
    output logic             out_valid,
    output result_t          out_res
);

    logic [1:0] valid_reg;

    logic [59:0]          ax_reg, az_reg;
    logic [47:0]          bx_reg, bz_reg;
    logic [31:0]          scale_reg;
    logic                 behind_reg, negx_reg, negz_reg;
    logic signed [CW-1:0] depth_reg;
    result_t              res_reg;

    logic [QW-1:0]      qx, qz, qs;
    logic [48:0]        bx_rnd, bz_rnd;
    logic [60:0]        prod_x, prod_z;
    logic signed [62:0] sv_x, sv_z;
    result_t            res_next;

    always_comb
    begin
        qx = in_cell.lx.nq;
        qz = in_cell.lz.nq;
        qs = in_cell.ls.nq;

        bx_rnd = {1'b0, bx_reg} + 49'd32768;
        bz_rnd = {1'b0, bz_reg} + 49'd32768;
        prod_x = {1'b0, ax_reg} + {28'd0, bx_rnd[48:16]};
        prod_z = {1'b0, az_reg} + {28'd0, bz_rnd[48:16]};
        sv_x   = negx_reg ? -$signed({2'b00, prod_x}) : $signed({2'b00, prod_x});
        sv_z   = negz_reg ? -$signed({2'b00, prod_z}) : $signed({2'b00, prod_z});

        res_next.depth  = {{(40-CW){depth_reg[CW-1]}}, depth_reg};
        res_next.behind = behind_reg;
        if (behind_reg)
        begin
            res_next.screen_x = OFFSCREEN;
            res_next.screen_y = OFFSCREEN;
            res_next.scale    = '0;
        end
        else
        begin
            res_next.screen_x = sat40(CENTER_X_Q + sv_x);
            res_next.screen_y = sat40(CENTER_Y_Q - sv_z);
            res_next.scale    = scale_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= focal_gain * qx[QW-1:16];
            bx_reg     <= focal_gain * qx[15:0];
            az_reg     <= focal_gain * qz[QW-1:16];
            bz_reg     <= focal_gain * qz[15:0];
            scale_reg  <= (qs[QW-1:32] != '0) ? 32'hFFFF_FFFF : qs[31:0];
            behind_reg <= in_cell.behind;
            negx_reg   <= in_cell.neg_x;
            negz_reg   <= in_cell.neg_z;
            depth_reg  <= in_cell.depth;
            res_reg    <= res_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== src/yaw_pitch_perspective_projector.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_perspective_projector
// Projects Q16.16 world points through a yaw/pitch camera onto the screen.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one world point per transaction (x, y, z), m_* one result:
//   screen x/y, depth and scale in tdata, the behind flag in tuser.
//   cfg_* writes the camera registers; write only while no point is in flight.
//   An input transaction reaches m_tvalid through the translation and rotation
//   stages, 44 division cells (one quotient bit each), the focal scaling and
//   saturation registers and the output register. Throughput is one point
//   per cycle while s_tready is high, set by the fully pipelined cell chain.
//   When the receiver stalls, a one-entry skid buffer takes the next result;
//   once it is full the whole pipeline and s_tready hold until m_tready.
//   Reset empties the pipeline and loads the identity camera: position zero,
//   cosines 1.0, sines 0, focal gain 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module yaw_pitch_perspective_projector import ypp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // world_x, world_y, world_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // screen_x, screen_y, depth, scale
    output logic [0:0]        m_tuser,   // behind
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [15:0] cos_yaw_reg, sin_yaw_reg, cos_pitch_reg, sin_pitch_reg;
    logic [31:0]        focal_reg;

    logic      en;
    logic      rot_valid;
    div_cell_t rot_cell;
    logic      fin_valid;
    result_t   fin_res;

    logic [QW:0] chain_valid;
    div_cell_t   chain_cell [QW+1];

    logic    m_tvalid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    take_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            cam_z_reg     <= '0;
            cos_yaw_reg   <= 16'sd16384;
            sin_yaw_reg   <= '0;
            cos_pitch_reg <= 16'sd16384;
            sin_pitch_reg <= '0;
            focal_reg     <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CAM_X:     cam_x_reg     <= cfg_data;
                REG_CAM_Y:     cam_y_reg     <= cfg_data;
                REG_CAM_Z:     cam_z_reg     <= cfg_data;
                REG_COS_YAW:   cos_yaw_reg   <= cfg_data[15:0];
                REG_SIN_YAW:   sin_yaw_reg   <= cfg_data[15:0];
                REG_COS_PITCH: cos_pitch_reg <= cfg_data[15:0];
                REG_SIN_PITCH: sin_pitch_reg <= cfg_data[15:0];
                REG_FOCAL:     focal_reg     <= cfg_data;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    ypp_rotate u_rotate
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid && s_tready),
        .world_x    (s_tdata[31:0]),
        .world_y    (s_tdata[63:32]),
        .world_z    (s_tdata[95:64]),
        .cam_x      (cam_x_reg),
        .cam_y      (cam_y_reg),
        .cam_z      (cam_z_reg),
        .cos_yaw    (cos_yaw_reg),
        .sin_yaw    (sin_yaw_reg),
        .cos_pitch  (cos_pitch_reg),
        .sin_pitch  (sin_pitch_reg),
        .focal_gain (focal_reg),
        .out_valid  (rot_valid),
        .out_cell   (rot_cell)
    );

    assign chain_valid[0] = rot_valid;
    assign chain_cell[0]  = rot_cell;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        ypp_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    ypp_finish u_finish
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .focal_gain (focal_reg),
        .in_valid   (chain_valid[QW]),
        .in_cell    (chain_cell[QW]),
        .out_valid  (fin_valid),
        .out_res    (fin_res)
    );

    assign take_out = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take_out)
        begin
            if (skid_valid_reg)
            begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                m_tvalid_reg <= fin_valid && en;
            end
        end
        else if (fin_valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin_res;
        end
        else if (fin_valid && en)
        begin
            skid_reg <= fin_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.scale, out_reg.depth, out_reg.screen_y, out_reg.screen_x};
    assign m_tuser  = out_reg.behind;

    `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, m_tvalid_reg, "skid full with empty output")
    `ASSERT_NXT(a_skid_hold, clk, rst_n, skid_valid_reg && m_tvalid_reg && !m_tready, skid_valid_reg, "skid lost during stall")
    `ASSERT_IMP(a_behind_forced, clk, rst_n, m_tvalid_reg && out_reg.behind, out_reg.scale == '0 && out_reg.screen_x == OFFSCREEN && out_reg.screen_y == OFFSCREEN, "behind result not forced")

endmodule

`default_nettype wire

// ===== tb/yaw_pitch_perspective_projector_tb.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_perspective_projector_tb
// Streams world points through the projector under several camera settings
// and compares every result against a cycle-free projection computed here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module yaw_pitch_perspective_projector_tb;
    import ypp_pkg::*;

    localparam int LATENCY     = 52;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint NEAR_Q  = 655;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] cam_reg [8];
    point_t pending_points [$];
    result_t expected_results [$];
    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit no_idle = 1'b0;
    bit hold_send = 1'b0;

    yaw_pitch_perspective_projector u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint round_q14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint clamp40(longint v);
        if (v > 64'sd549755813887)
        begin
            return 64'sd549755813887;
        end
        if (v < -64'sd549755813888)
        begin
            return -64'sd549755813888;
        end
        return v;
    endfunction

    // focal * num / den with rounding on the magnitude
    function automatic longint focal_ratio(longint unsigned focal, longint num, longint den);
        bit neg;
        longint unsigned mag;
        longint unsigned ratio;
        longint unsigned prod;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        ratio = ((mag << 17) + den) / (2 * den);
        prod = focal * (ratio >> 16) + ((focal * (ratio & 16'hFFFF) + 32768) >> 16);
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic result_t project_point(point_t p);
        longint px, py, pz, cy, sy, cp, sp, x1, y1, yc, zc;
        longint unsigned focal, sc;
        result_t r;
        px = longint'(signed'(p.x)) - longint'(signed'(cam_reg[REG_CAM_X]));
        py = longint'(signed'(p.y)) - longint'(signed'(cam_reg[REG_CAM_Y]));
        pz = longint'(signed'(p.z)) - longint'(signed'(cam_reg[REG_CAM_Z]));
        cy = longint'(signed'(cam_reg[REG_COS_YAW][15:0]));
        sy = longint'(signed'(cam_reg[REG_SIN_YAW][15:0]));
        cp = longint'(signed'(cam_reg[REG_COS_PITCH][15:0]));
        sp = longint'(signed'(cam_reg[REG_SIN_PITCH][15:0]));
        focal = cam_reg[REG_FOCAL];
        x1 = round_q14(px * cy + py * sy);
        y1 = round_q14(-px * sy + py * cy);
        yc = round_q14(y1 * cp + pz * sp);
        zc = round_q14(y1 * sp - pz * cp);
        r.depth = clamp40(yc);
        if (yc <= NEAR_Q)
        begin
            r.screen_x = OFFSCREEN;
            r.screen_y = OFFSCREEN;
            r.scale = '0;
            r.behind = 1'b1;
        end
        else
        begin
            r.screen_x = clamp40(640 * 65536 + focal_ratio(focal, x1, yc));
            r.screen_y = clamp40(360 * 65536 - focal_ratio(focal, zc, yc));
            sc = ((focal << 17) + yc) / (2 * yc);
            r.scale = (sc > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sc[31:0];
            r.behind = 1'b0;
        end
        return r;
    endfunction

    // point sender
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (s_tvalid && s_tready)
        begin
            expected_results.push_back(project_point(pending_points.pop_front()));
        end
        if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (!no_idle && $urandom_range(0, 15) == 0)
            begin
                send_gap <= $urandom_range(1, 8);
                s_tvalid <= 1'b0;
            end
            else if (!hold_send && pending_points.size() > 0)
            begin
                point_t nxt;
                nxt = pending_points[0];
                s_tvalid <= 1'b1;
                s_tdata <= {nxt.z, nxt.y, nxt.x};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction");
                errors = errors + 1;
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (m_tdata[39:0] !== e.screen_x)
                begin
                    $error("screen_x expected %h got %h", e.screen_x, m_tdata[39:0]);
                    errors = errors + 1;
                end
                if (m_tdata[79:40] !== e.screen_y)
                begin
                    $error("screen_y expected %h got %h", e.screen_y, m_tdata[79:40]);
                    errors = errors + 1;
                end
                if (m_tdata[119:80] !== e.depth)
                begin
                    $error("depth expected %h got %h", e.depth, m_tdata[119:80]);
                    errors = errors + 1;
                end
                if (m_tdata[151:120] !== e.scale)
                begin
                    $error("scale expected %h got %h", e.scale, m_tdata[151:120]);
                    errors = errors + 1;
                end
                if (m_tuser[0] !== e.behind)
                begin
                    $error("behind expected %b got %b", e.behind, m_tuser[0]);
                    errors = errors + 1;
                end
            end
        end
        if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 15) == 0)
        begin
            recv_gap <= $urandom_range(1, 8);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("yaw_pitch_perspective_projector_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cam_reg[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points.push_back(p);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_trig();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_C000;
            1: return 32'd16384;
            2: return 32'hFFFF_8000;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_points(int n);
        repeat (n)
        begin
            add_point(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] c_y, logic [31:0] s_y,
                              logic [31:0] c_p, logic [31:0] s_p, logic [31:0] f);
        write_reg(REG_CAM_X, cx);
        write_reg(REG_CAM_Y, cy);
        write_reg(REG_CAM_Z, cz);
        write_reg(REG_COS_YAW, c_y);
        write_reg(REG_SIN_YAW, s_y);
        write_reg(REG_COS_PITCH, c_p);
        write_reg(REG_SIN_PITCH, s_p);
        write_reg(REG_FOCAL, f);
    endtask

    initial
    begin
        cam_reg = '{0, 0, 0, 16384, 0, 16384, 0, 65536};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // identity camera: extremes, near limit, behind, halves
        add_point(0, 32'd655, 0);
        add_point(0, 32'd656, 0);
        add_point(0, 0, 0);
        add_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_point(32'h7FFFFFFF, 32'd656, 32'h80000000);
        add_point(32'h80000000, 32'd656, 32'h7FFFFFFF);
        add_point(32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        add_point(32'h00010000, 32'h00020000, 32'hFFFF0000);
        add_point(32'd1, 32'd3, 32'd1);
        add_point(32'hFFFFFFFF, 32'd2, 32'hFFFFFFFF);
        add_point(32'h55555555, 32'h2AAAAAAA, 32'hAAAAAAAA);
        drain();

        set_camera(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                   32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 32'd16384, 32'hFFFFFFFF);
        add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        add_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        add_point(0, 0, 0);
        add_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        random_points(100);
        drain();

        // deliberate stop of the sender until every result is back
        set_camera(0, 0, 0, 16384, 0, 16384, 0, 0);
        random_points(50);
        wait (pending_points.size() < 25);
        hold_send = 1'b1;
        wait (!s_tvalid && expected_results.size() == 0);
        repeat (4) @(posedge clk);
        hold_send = 1'b0;
        drain();

        repeat (6)
        begin
            set_camera($urandom_range(0, 1) ? rand_coord() : 0, rand_coord(),
                       $urandom_range(0, 1) ? rand_coord() : 0,
                       rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                       $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(1, 1 << 22));
            random_points(170);
            drain();
        end

        set_camera(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                   32'd11585, 32'd11585, 32'hFFFFD2BF, 32'd11585, 32'd65536 * 500);
        no_idle = 1'b1;
        random_points(120);
        drain();

        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("yaw_pitch_perspective_projector_tb: clean");
        end
        else
        begin
            $display("yaw_pitch_perspective_projector_tb: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/ypp_pkg.sv
src/ypp_rotate.sv
src/ypp_div_cell.sv
src/ypp_finish.sv
src/yaw_pitch_perspective_projector.sv
tb/yaw_pitch_perspective_projector_tb.sv
